[hdl/dss_pkg.sv]
`timescale 1ns / 1ps

package dss_pkg;

  localparam int CYL_W     = 16;
  localparam int SEEK_W    = 23;
  localparam int SIZE_W    = 17;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int TURN_W    = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 2'd2;

  // service orders
  localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  localparam logic [SIZE_W-1:0] DISK_SIZE_RESET = 17'h10000;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]  served_cylinder;
    logic [SEEK_W-1:0] seek_total;
    logic              last_result;
    logic              overflow;
  } out_item_t;

  // sorted lane operations
  typedef enum logic [1:0] {
    SV_HOLD,
    SV_INSERT,
    SV_SHIFT
  } sv_op_t;

  // arrival / lower-group lane operations
  typedef enum logic [1:0] {
    AV_HOLD,
    AV_APPEND,
    AV_PUSH,
    AV_SHIFT
  } av_op_t;

  typedef struct packed {
    sv_op_t           sv_op;
    av_op_t           av_op;
    logic [CYL_W-1:0] data;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SKIP,
    ST_UP,
    ST_POP
  } state_t;

endpackage

[hdl/dss_cell.sv]
`timescale 1ns / 1ps

module dss_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                        clk,
  input  dss_pkg::cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]            sel,
  input  logic                        left_gt,
  input  logic [dss_pkg::CYL_W-1:0]   left_sv,
  input  logic [dss_pkg::CYL_W-1:0]   left_av,
  input  logic [dss_pkg::CYL_W-1:0]   right_sv,
  input  logic [dss_pkg::CYL_W-1:0]   right_av,
  output logic [dss_pkg::CYL_W-1:0]   sv,
  output logic [dss_pkg::CYL_W-1:0]   av,
  output logic                        gt
);

  logic [dss_pkg::CYL_W-1:0] sv_r, sv_nxt;
  logic [dss_pkg::CYL_W-1:0] av_r, av_nxt;
  logic                      empty;

  // cells at or beyond the fill count hold nothing and sort as infinity
  assign empty = (CNT_W'(IDX) >= sel);
  assign gt    = empty || (sv_r > cmd.data);

  always_comb begin
    case (cmd.sv_op)
      dss_pkg::SV_INSERT: sv_nxt = gt ? (left_gt ? left_sv : cmd.data) : sv_r;
      dss_pkg::SV_SHIFT:  sv_nxt = right_sv;
      default:            sv_nxt = sv_r;
    endcase
  end

  always_comb begin
    case (cmd.av_op)
      dss_pkg::AV_APPEND: av_nxt = (sel == CNT_W'(IDX)) ? cmd.data : av_r;
      dss_pkg::AV_PUSH:   av_nxt = left_av;
      dss_pkg::AV_SHIFT:  av_nxt = right_av;
      default:            av_nxt = av_r;
    endcase
  end

  always_ff @(posedge clk) begin
    sv_r <= sv_nxt;
    av_r <= av_nxt;
  end

  assign sv = sv_r;
  assign av = av_r;

endmodule

[hdl/disk_seek_scheduler.sv]
`timescale 1ns / 1ps

// Disk seek scheduler. Requests are transferred in one per cycle and kept in a
// row of cells: one lane is kept in ascending cylinder order by insertion, the
// other in arrival order. The request flagged last closes the batch; from then
// on the input is stalled until every result of the batch has been loaded into
// the output register. FCFS gives one result a cycle while the output is not
// stalled. SCAN and C-SCAN first walk the requests at or below the head out of
// cell 0 of the sorted lane into the second lane, one at a time, plus a step
// that finds the first request above the head, then give one result a cycle
// while the output is not stalled; when every request lies at or below the
// head, the turn takes a step of its own. Both lanes are read only at cell 0,
// into a one-deep output register. Requests above the last cylinder are
// clamped on arrival; requests past MAX_REQUESTS are dropped and set overflow
// on every result of that batch. Each batch starts with the head at
// start_head, clamped to the disk. The seek total of the final result is the
// whole batch travel; in SCAN and C-SCAN it includes end-of-disk travel and
// the C-SCAN return jump. cfg_ready is always high.

module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dss_pkg::in_item_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output dss_pkg::out_item_t                out_data,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dss_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int CYL_W = dss_pkg::CYL_W;
  localparam int SEEK_W = dss_pkg::SEEK_W;
  localparam int TURN_W = dss_pkg::TURN_W;

  // configuration registers
  logic [dss_pkg::MODE_W-1:0] mode_r;
  logic [CYL_W-1:0]           head_r;
  logic [dss_pkg::SIZE_W-1:0] size_r;

  // control state
  dss_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // arrivals, then uppers left in the sorted lane
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt;   // results left in the second lane
  logic             drop_r, drop_nxt;

  // serving datapath
  logic [CYL_W-1:0]  pos_r, pos_nxt;
  logic [SEEK_W-1:0] acc_r, acc_nxt;
  logic [TURN_W-1:0] turn_r, turn_nxt;  // batch total at the turn point

  // output register
  logic               out_valid_r, out_valid_nxt;
  dss_pkg::out_item_t out_data_r;
  logic               load;
  dss_pkg::out_item_t load_data;

  // cell row
  dss_pkg::cell_cmd_t cmd;
  logic [CNT_W-1:0]   sel;
  logic [CYL_W-1:0]   sv_w [MAX_REQUESTS];
  logic [CYL_W-1:0]   av_w [MAX_REQUESTS];
  logic               gt_w [MAX_REQUESTS];

  logic             in_fire, cfg_fire, emit_ok;
  logic             room, scan_mode, cscan;
  logic             skip_go;
  logic [CYL_W-1:0] endc, cyl_cl, head_cl, turn_pos, cur, gap;
  logic [SEEK_W-1:0] acc_plus;
  logic [TURN_W-1:0] turn_calc;

  assign in_stall  = (state_r != dss_pkg::ST_COLLECT);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign emit_ok   = !out_valid_r || !out_stall;

  // last cylinder, with zero and oversize disks folded into range
  always_comb begin
    if (size_r == '0) begin
      endc = '0;
    end else if (size_r[dss_pkg::SIZE_W-1]) begin
      endc = '1;
    end else begin
      endc = size_r[CYL_W-1:0] - CYL_W'(1);
    end
  end

  assign cyl_cl    = (in_data.request_cylinder > endc) ? endc : in_data.request_cylinder;
  assign head_cl   = (head_r > endc) ? endc : head_r;
  assign room      = (cnt_r < CNT_W'(MAX_REQUESTS));
  assign cscan     = (mode_r == dss_pkg::MODE_CSCAN);
  assign scan_mode = (mode_r == dss_pkg::MODE_SCAN) || cscan;

  // uppers are served ascending from the head, so their travel plus the end
  // travel is just last cylinder minus head; c-scan adds the return jump
  assign turn_calc = TURN_W'(endc - head_cl) + (cscan ? TURN_W'(endc) : TURN_W'(0));
  assign turn_pos  = cscan ? '0 : endc;

  assign skip_go  = (cnt_r != '0) && (sv_w[0] <= pos_r);
  assign cur      = (state_r == dss_pkg::ST_POP) ? av_w[0] : sv_w[0];
  assign gap      = (cur > pos_r) ? (cur - pos_r) : (pos_r - cur);
  assign acc_plus = acc_r + SEEK_W'(gap);

  // cell row: cell 0 takes new data from the left, shifting moves toward cell 0
  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    logic             l_gt;
    logic [CYL_W-1:0] l_sv, l_av, r_sv, r_av;
    if (i == 0) begin : g_first
      assign l_gt = 1'b0;
      assign l_sv = cmd.data;
      assign l_av = cmd.data;
    end else begin : g_mid
      assign l_gt = gt_w[i-1];
      assign l_sv = sv_w[i-1];
      assign l_av = av_w[i-1];
    end
    if (i == MAX_REQUESTS - 1) begin : g_last
      assign r_sv = '0;
      assign r_av = '0;
    end else begin : g_inner
      assign r_sv = sv_w[i+1];
      assign r_av = av_w[i+1];
    end
    dss_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .sel      (sel),
      .left_gt  (l_gt),
      .left_sv  (l_sv),
      .left_av  (l_av),
      .right_sv (r_sv),
      .right_av (r_av),
      .sv       (sv_w[i]),
      .av       (av_w[i]),
      .gt       (gt_w[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dss_pkg::ST_COLLECT: begin
        if (in_fire && in_data.last_request) begin
          state_nxt = scan_mode ? dss_pkg::ST_SKIP : dss_pkg::ST_POP;
        end
      end
      dss_pkg::ST_SKIP: begin
        if (!skip_go) begin
          state_nxt = dss_pkg::ST_UP;
        end
      end
      dss_pkg::ST_UP: begin
        if (cnt_r == '0) begin
          state_nxt = dss_pkg::ST_POP;
        end else if (emit_ok && cnt_r == CNT_W'(1)) begin
          state_nxt = (lcnt_r == '0) ? dss_pkg::ST_COLLECT : dss_pkg::ST_POP;
        end
      end
      dss_pkg::ST_POP: begin
        if (emit_ok && lcnt_r == CNT_W'(1)) begin
          state_nxt = dss_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = dss_pkg::ST_COLLECT;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    cmd       = '{sv_op: dss_pkg::SV_HOLD, av_op: dss_pkg::AV_HOLD, data: '0};
    sel       = cnt_r;
    cnt_nxt   = cnt_r;
    lcnt_nxt  = lcnt_r;
    drop_nxt  = drop_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    turn_nxt  = turn_r;
    load      = 1'b0;
    load_data = '0;
    case (state_r)
      dss_pkg::ST_COLLECT: begin
        if (in_fire) begin
          cmd.data = cyl_cl;
          if (room) begin
            cmd.sv_op = dss_pkg::SV_INSERT;
            cmd.av_op = dss_pkg::AV_APPEND;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_request) begin
            pos_nxt  = head_cl;
            acc_nxt  = '0;
            turn_nxt = turn_calc;
            if (scan_mode) begin
              lcnt_nxt = '0;
            end else begin
              // arrival lane is served directly; sorted lane is abandoned
              lcnt_nxt = room ? cnt_r + CNT_W'(1) : cnt_r;
              cnt_nxt  = '0;
            end
          end
        end
      end
      dss_pkg::ST_SKIP: begin
        // move requests at or below the head into the second lane:
        // stacked for scan (served descending), queued for c-scan
        sel = lcnt_r;
        if (skip_go) begin
          cmd.sv_op = dss_pkg::SV_SHIFT;
          cmd.av_op = cscan ? dss_pkg::AV_APPEND : dss_pkg::AV_PUSH;
          cmd.data  = sv_w[0];
          cnt_nxt   = cnt_r - CNT_W'(1);
          lcnt_nxt  = lcnt_r + CNT_W'(1);
        end
      end
      dss_pkg::ST_UP: begin
        if (cnt_r == '0) begin
          // no upper group: turn at once
          acc_nxt = SEEK_W'(turn_r);
          pos_nxt = turn_pos;
        end else if (emit_ok) begin
          load                      = 1'b1;
          load_data.served_cylinder = sv_w[0];
          load_data.overflow        = drop_r;
          if (cnt_r == CNT_W'(1) && lcnt_r == '0) begin
            // final result carries the end travel as well
            load_data.seek_total  = SEEK_W'(turn_r);
            load_data.last_result = 1'b1;
          end else begin
            load_data.seek_total  = acc_plus;
            load_data.last_result = 1'b0;
          end
          cmd.sv_op = dss_pkg::SV_SHIFT;
          cnt_nxt   = cnt_r - CNT_W'(1);
          pos_nxt   = sv_w[0];
          acc_nxt   = acc_plus;
          if (cnt_r == CNT_W'(1)) begin
            if (lcnt_r == '0) begin
              drop_nxt = 1'b0;
            end else begin
              acc_nxt = SEEK_W'(turn_r);
              pos_nxt = turn_pos;
            end
          end
        end
      end
      dss_pkg::ST_POP: begin
        if (emit_ok) begin
          load                      = 1'b1;
          load_data.served_cylinder = av_w[0];
          load_data.seek_total      = acc_plus;
          load_data.last_result     = (lcnt_r == CNT_W'(1));
          load_data.overflow        = drop_r;
          cmd.av_op = dss_pkg::AV_SHIFT;
          lcnt_nxt  = lcnt_r - CNT_W'(1);
          pos_nxt   = av_w[0];
          acc_nxt   = acc_plus;
          if (lcnt_r == CNT_W'(1)) begin
            drop_nxt = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt  = '0;
        lcnt_nxt = '0;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dss_pkg::ST_COLLECT;
      cnt_r       <= '0;
      lcnt_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= dss_pkg::MODE_FCFS;
      head_r      <= '0;
      size_r      <= dss_pkg::DISK_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lcnt_r      <= lcnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          dss_pkg::CFG_MODE:       mode_r <= cfg_data[dss_pkg::MODE_W-1:0];
          dss_pkg::CFG_START_HEAD: head_r <= cfg_data[CYL_W-1:0];
          dss_pkg::CFG_DISK_SIZE:  size_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    acc_r  <= acc_nxt;
    turn_r <= turn_nxt;
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the final result of a batch always reopens the request channel
  a_done_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    load && load_data.last_result |=> state_r == dss_pkg::ST_COLLECT)
    else $error("batch end did not return to collecting");

  // second lane is empty whenever requests are being collected
  a_collect_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dss_pkg::ST_COLLECT |-> lcnt_r == '0)
    else $error("lower lane not drained at batch end");

  // serving from the second lane only with something left in it
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dss_pkg::ST_POP |-> lcnt_r != '0)
    else $error("serving from an empty lane");

  // fill counts stay within the row
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(MAX_REQUESTS)) && (lcnt_r <= CNT_W'(MAX_REQUESTS)))
    else $error("cell row count out of range");

endmodule

[sim/seek_order_checker.sv]
`timescale 1ns / 1ps

module seek_order_checker #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  dss_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  dss_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::SIZE_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            batches_closed,
  output int                            results_checked,
  output int                            overflow_batches
);

  localparam int CYL_W    = dss_pkg::CYL_W;
  localparam int SEEK_W   = dss_pkg::SEEK_W;
  localparam int SIZE_W   = dss_pkg::SIZE_W;
  localparam int MODE_W   = dss_pkg::MODE_W;
  localparam int SEEK_MAX = (1 << SEEK_W) - 1;

  logic [MODE_W-1:0]  mode_q       = dss_pkg::MODE_FCFS;
  logic [CYL_W-1:0]   start_head_q = '0;
  logic [SIZE_W-1:0]  disk_size_q  = dss_pkg::DISK_SIZE_RESET;
  logic [CYL_W-1:0]   request_q [MAX_REQUESTS];
  int                 stored  = 0;
  logic               dropped = 1'b0;
  dss_pkg::out_item_t service_queue [$];
  int                 travel;
  int                 head_at;
  int                 fails     = 0;
  int                 batches   = 0;
  int                 checked   = 0;
  int                 overflows = 0;

  function automatic int last_cylinder();
    int size_eff;
    size_eff = int'(disk_size_q);
    if (size_eff == 0) size_eff = 1;
    if (size_eff > (1 << CYL_W)) size_eff = 1 << CYL_W;
    return size_eff - 1;
  endfunction

  function automatic void add_travel(input int gap);
    travel = (travel + gap > SEEK_MAX) ? SEEK_MAX : travel + gap;
  endfunction

  function automatic void serve_cylinder(input int cyl);
    dss_pkg::out_item_t item;
    add_travel(cyl > head_at ? cyl - head_at : head_at - cyl);
    head_at              = cyl;
    item.served_cylinder = cyl[CYL_W-1:0];
    item.seek_total      = travel[SEEK_W-1:0];
    item.last_result     = 1'b0;
    item.overflow        = dropped;
    service_queue.push_back(item);
  endfunction

  // works out the whole service order of the batch just closed
  function automatic void plan_service_order();
    logic [CYL_W-1:0]   sorted [MAX_REQUESTS];
    logic [CYL_W-1:0]   v;
    int                 endc;
    int                 split;
    int                 j;
    dss_pkg::out_item_t tail;
    endc    = last_cylinder();
    head_at = (int'(start_head_q) > endc) ? endc : int'(start_head_q);
    travel  = 0;
    if (mode_q == dss_pkg::MODE_SCAN || mode_q == dss_pkg::MODE_CSCAN) begin
      for (int i = 0; i < stored; i++) begin
        v = request_q[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      // first request strictly above the head
      split = stored;
      for (int i = stored - 1; i >= 0; i--) begin
        if (int'(sorted[i]) > head_at) split = i;
      end
      for (int i = split; i < stored; i++) serve_cylinder(int'(sorted[i]));
      add_travel(endc - head_at);
      if (mode_q == dss_pkg::MODE_SCAN) begin
        head_at = endc;
        for (int i = split - 1; i >= 0; i--) serve_cylinder(int'(sorted[i]));
      end else begin
        add_travel(endc);
        head_at = 0;
        for (int i = 0; i < split; i++) serve_cylinder(int'(sorted[i]));
      end
    end else begin
      for (int i = 0; i < stored; i++) serve_cylinder(int'(request_q[i]));
    end
    // final result carries the whole batch travel
    tail             = service_queue.pop_back();
    tail.seek_total  = travel[SEEK_W-1:0];
    tail.last_result = 1'b1;
    service_queue.push_back(tail);
  endfunction

  always @(posedge clk) begin
    dss_pkg::out_item_t want;
    logic [CYL_W-1:0]   cyl;
    if (!rst_n) begin
      mode_q       = dss_pkg::MODE_FCFS;
      start_head_q = '0;
      disk_size_q  = dss_pkg::DISK_SIZE_RESET;
      stored       = 0;
      dropped      = 1'b0;
      service_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (service_queue.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result cyl %0d seek %0d last %0b ovf %0b", $time,
                     out_data.served_cylinder, out_data.seek_total, out_data.last_result,
                     out_data.overflow);
        end else begin
          want = service_queue.pop_front();
          checked++;
          if (out_data.served_cylinder !== want.served_cylinder ||
              out_data.seek_total !== want.seek_total ||
              out_data.last_result !== want.last_result ||
              out_data.overflow !== want.overflow) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result mismatch, expected cyl %0d seek %0d last %0b ovf %0b, %s",
                       $time, want.served_cylinder, want.seek_total, want.last_result,
                       want.overflow,
                       $sformatf("got cyl %0d seek %0d last %0b ovf %0b",
                                 out_data.served_cylinder, out_data.seek_total,
                                 out_data.last_result, out_data.overflow));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dss_pkg::CFG_MODE:       mode_q       = cfg_data[MODE_W-1:0];
          dss_pkg::CFG_START_HEAD: start_head_q = cfg_data[CYL_W-1:0];
          dss_pkg::CFG_DISK_SIZE:  disk_size_q  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cyl = (int'(in_data.request_cylinder) > last_cylinder()) ? CYL_W'(last_cylinder())
                                                                  : in_data.request_cylinder;
        if (stored < MAX_REQUESTS) begin
          request_q[stored] = cyl;
          stored++;
        end else begin
          dropped = 1'b1;
        end
        if (in_data.last_request) begin
          plan_service_order();
          batches++;
          if (dropped) overflows++;
          stored  = 0;
          dropped = 1'b0;
        end
      end
    end
    fail_count       <= fails;
    outstanding      <= service_queue.size();
    batches_closed   <= batches;
    results_checked  <= checked;
    overflow_batches <= overflows;
  end

endmodule

[sim/disk_seek_scheduler_test.sv]
`timescale 1ns / 1ps

module disk_seek_scheduler_test;

  localparam int MAX_REQUESTS = 64;
  localparam int CYL_W     = dss_pkg::CYL_W;
  localparam int MODE_W    = dss_pkg::MODE_W;
  localparam int SIZE_W    = dss_pkg::SIZE_W;
  localparam int CFG_IDX_W = dss_pkg::CFG_IDX_W;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  // spare mode code, serves like fcfs
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYL_TOP         = (1 << CYL_W) - 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  dss_pkg::in_item_t    in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  dss_pkg::out_item_t   out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = dss_pkg::CFG_MODE;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  int fail_count;
  int outstanding;
  int batches_closed;
  int results_checked;
  int overflow_batches;

  // idle chance in percent for each side
  int send_idle_pct = 8;
  int recv_idle_pct = 54;

  // long receiver hold-off, requested by the stimulus and counted by the receiver
  int hold_trigger = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // requests of the batch about to go out
  logic [CYL_W-1:0] batch_cyls [$];

  // current head and disk size, used to aim random cylinders
  int head_now = 0;
  int size_now = 1 << CYL_W;

  always #5 clk = ~clk;

  disk_seek_scheduler #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  seek_order_checker #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .batches_closed  (batches_closed),
    .results_checked (results_checked),
    .overflow_batches(overflow_batches)
  );

  // result side: random stall, or a long hold-off once the stimulus asks for one
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one request transfer; valid stays high afterwards so that back-to-back
  // transfers never lower and raise it in the same step
  task automatic send_request(input logic [CYL_W-1:0] cyl, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{request_cylinder: cyl, last_request: is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // the final request of the queue is flagged as closing the batch
  task automatic send_batch();
    for (int i = 0; i < batch_cyls.size(); i++)
      send_request(batch_cyls[i], i == batch_cyls.size() - 1);
  endtask

  // sender goes quiet until every predicted result has been transferred,
  // then lets the block settle before any register write
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all three registers; unused upper data bits carry noise
  task automatic configure(input logic [MODE_W-1:0] mode_val, input logic [CYL_W-1:0] head_val,
                           input logic [SIZE_W-1:0] size_val);
    write_reg(dss_pkg::CFG_MODE, {(SIZE_W-MODE_W)'($urandom), mode_val});
    write_reg(dss_pkg::CFG_START_HEAD, {(SIZE_W-CYL_W)'($urandom), head_val});
    write_reg(dss_pkg::CFG_DISK_SIZE, size_val);
    cfg_valid <= 1'b0;
    head_now = int'(head_val);
    size_now = int'(size_val);
  endtask

  task automatic random_configure();
    logic [MODE_W-1:0] mode_val;
    logic [CYL_W-1:0]  head_val;
    logic [SIZE_W-1:0] size_val;
    mode_val = MODE_W'($urandom_range(3));
    case ($urandom_range(9))
      0:       size_val = '0;
      1:       size_val = SIZE_W'(1);
      2:       size_val = SIZE_W'($urandom_range(131071, 65537));
      3, 4:    size_val = SIZE_W'($urandom_range(300, 2));
      5, 6:    size_val = SIZE_W'($urandom_range(65535, 300));
      default: size_val = dss_pkg::DISK_SIZE_RESET;
    endcase
    case ($urandom_range(7))
      0:       head_val = '0;
      1:       head_val = CYL_W'(CYL_TOP);
      2, 3:    head_val = CYL_W'($urandom_range((size_val > 1) ? size_val - 1 : 0));
      default: head_val = CYL_W'($urandom);
    endcase
    configure(mode_val, head_val, size_val);
  endtask

  // mix of extremes, the head itself, its neighbours, in-range and full-range values
  function automatic logic [CYL_W-1:0] pick_cylinder();
    int limit;
    limit = (size_now == 0) ? 1 : ((size_now > (1 << CYL_W)) ? (1 << CYL_W) : size_now);
    case ($urandom_range(9))
      0:          return '0;
      1:          return CYL_W'(CYL_TOP);
      2:          return CYL_W'(head_now);
      3:          return CYL_W'(head_now + $urandom_range(4) - 2);
      4, 5, 6:    return CYL_W'($urandom_range(limit - 1));
      default:    return CYL_W'($urandom);
    endcase
  endfunction

  task automatic fill_random_batch(input int len);
    batch_cyls.delete();
    repeat (len) batch_cyls.push_back(pick_cylinder());
  endtask

  // mostly short batches, now and then a longer one; registers change between
  // batches only once the block has gone idle
  task automatic run_random(input int goal);
    int sent;
    int len;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(3) == 0) begin
        drain();
        random_configure();
      end else if ($urandom_range(9) == 0) begin
        drain();
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      fill_random_batch(len);
      send_batch();
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fcfs, head at 0, full disk, cylinder extremes
    batch_cyls = '{16'hFFFF, 16'd0, 16'hFFFF};
    send_batch();
    drain();

    // scan with duplicates and a request sitting on the head (lower group)
    configure(dss_pkg::MODE_SCAN, 16'd100, dss_pkg::DISK_SIZE_RESET);
    batch_cyls = '{16'd150, 16'd100, 16'd20, 16'd300, 16'd100};
    send_batch();
    drain();

    // scan with nothing below the head, one request clamped to the disk end
    configure(dss_pkg::MODE_SCAN, 16'd500, 17'd1000);
    batch_cyls = '{16'd600, 16'd4000};
    send_batch();
    drain();

    // c-scan on a small disk, both groups present
    configure(dss_pkg::MODE_CSCAN, 16'd500, 17'd1000);
    batch_cyls = '{16'd10, 16'd999, 16'd500, 16'd700};
    send_batch();
    drain();

    // c-scan with every request at or below the head
    configure(dss_pkg::MODE_CSCAN, 16'hFFFF, dss_pkg::DISK_SIZE_RESET);
    batch_cyls = '{16'd0, 16'hFFFF};
    send_batch();
    drain();

    // start head beyond the disk end gets pulled back to the last cylinder
    configure(dss_pkg::MODE_SCAN, 16'd2000, 17'd1000);
    batch_cyls = '{16'd5, 16'd1500};
    send_batch();
    drain();

    // spare mode code on a zero-sized disk: everything lands on cylinder 0
    configure(MODE_SPARE, 16'd7, 17'd0);
    batch_cyls = '{16'd1, 16'hFFFF};
    send_batch();
    drain();

    // oversized disk is capped at the full cylinder range, single request
    configure(dss_pkg::MODE_CSCAN, 16'd3, 17'h1FFFF);
    batch_cyls = '{16'hFFFF};
    send_batch();
    drain();

    // write to a missing register has no effect
    write_reg(CFG_NO_REG, '1);
    configure(dss_pkg::MODE_FCFS, 16'd40000, dss_pkg::DISK_SIZE_RESET);
    batch_cyls = '{16'd12345};
    send_batch();
    drain();

    // one-cylinder disk
    configure(dss_pkg::MODE_SCAN, 16'd0, 17'd1);
    batch_cyls = '{16'd0, 16'd0, 16'd9};
    send_batch();
    drain();

    // random traffic, receiver stalling often
    run_random(70);

    // sender idling often, receiver rarely
    send_idle_pct = 54;
    recv_idle_pct <= 8;
    run_random(70);

    // full rate; the receiver holds off while an oversized batch goes in, so the
    // store overflows (the closing request itself is dropped) and the input stalls
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    drain();
    configure(dss_pkg::MODE_CSCAN, 16'd30000, dss_pkg::DISK_SIZE_RESET);
    hold_trigger <= hold_trigger + 1;
    fill_random_batch(MAX_REQUESTS + 3);
    send_batch();
    fill_random_batch(3);
    send_batch();
    drain();
    run_random(30);

    drain();
    repeat (16) @(posedge clk);
    $display("%0d batches closed, %0d results checked, %0d batches overflowed",
             batches_closed, results_checked, overflow_batches);
    $display("all service orders, clamped heads and requests, disk sizes 0 to 131071, back-pressure");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/dss_pkg.sv
hdl/dss_cell.sv
hdl/disk_seek_scheduler.sv
sim/seek_order_checker.sv
sim/disk_seek_scheduler_test.sv
